// ----- hdl/aep_pkg.sv -----
// Shared types, constants and helper functions for the ANSI escape parser.
package aep_pkg;

  localparam int MAX_PARAMS = 8;
  localparam int PARAM_BITS = 16;
  // parameter count holds 0..MAX_PARAMS, walk index holds 0..MAX_PARAMS-1
  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W = $clog2(MAX_PARAMS);
  // signed working width for cursor arithmetic
  localparam int SUM_W = PARAM_BITS + 2;
  localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

  // result kinds
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_COLOR  = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_FILL   = 3'd4;
  localparam logic [2:0] KIND_VIS    = 3'd5;

  localparam logic [7:0] CH_ESC = 8'h1B;

  // register offsets (decoded on paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [7:0] ROWS_RESET = 8'd25;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [3:0] BG_DEFAULT = 4'd0;

  // controller to datapath
  typedef struct packed {
    logic             latch_in;
    logic             load_out;
    logic             commit;
    logic [1:0]       step;
    logic             walk;
    logic [IDX_W-1:0] walk_idx;
  } aep_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]       n_res;
    logic             is_sgr;
    logic             out_free;
    logic [CNT_W-1:0] sgr_cnt;
  } aep_status_t;

  // SGR foreground mapping
  function automatic logic [3:0] map_fg(logic [PARAM_BITS-1:0] c, logic [3:0] cur);
    logic [3:0] r;
    r = cur;
    if (c >= PARAM_BITS'(30) && c <= PARAM_BITS'(37)) r = 4'(c - PARAM_BITS'(30));
    else if (c == PARAM_BITS'(39)) r = FG_DEFAULT;
    else if (c >= PARAM_BITS'(90) && c <= PARAM_BITS'(97)) r = 4'(c - PARAM_BITS'(82));
    return r;
  endfunction

  // SGR background mapping
  function automatic logic [3:0] map_bg(logic [PARAM_BITS-1:0] c, logic [3:0] cur);
    logic [3:0] r;
    r = cur;
    if (c >= PARAM_BITS'(40) && c <= PARAM_BITS'(47)) r = 4'(c - PARAM_BITS'(40));
    else if (c == PARAM_BITS'(49)) r = BG_DEFAULT;
    else if (c >= PARAM_BITS'(100) && c <= PARAM_BITS'(107)) r = 4'(c - PARAM_BITS'(92));
    return r;
  endfunction

  // clamp a signed coordinate into 0..hi
  function automatic logic [7:0] clamp_pos(logic signed [SUM_W-1:0] v, logic [7:0] hi);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > $signed({{(SUM_W-8){1'b0}}, hi})) r = hi;
    else r = v[7:0];
    return r;
  endfunction

endpackage

// ----- hdl/ansi_escape_parser_unit.sv -----
// Top level of the ANSI escape parser: APB registers, controller and datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_stall  | byte_in, cur_row, cur_col
//  out     | output    | out_valid / out_stall| kind, char_out, colours, target, ...
//  cfg     | input     | APB psel / penable   | screen_rows (0x0), screen_cols (0x4)
//
// An item is accepted, then decoded and loaded into the output register, one
// result at a time; an item with no result finishes without a load.
// An SGR final first enters the colour walk, which steps through the parameter
// registers one at a time (at least one, up to 8) before its result is loaded.
// Synchronous active-high reset; no clearing pass. A stalled output register
// holds the item and the sequencer waits for it to drain.
module ansi_escape_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic [7:0] cur_row,
  input  logic [7:0] cur_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] char_out,
  output logic [3:0] fore_color,
  output logic [3:0] back_color,
  output logic [7:0] target_row,
  output logic [7:0] target_col,
  output logic [7:0] fill_count,
  output logic       show_cursor,
  output logic       last
);
  import aep_pkg::*;

  aep_cmd_t    cmd;
  aep_status_t st;
  logic        cfg_we;
  logic [7:0]  cfg_rdata;

  // APB: zero wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = {24'd0, cfg_rdata};

  aep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  aep_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .byte_in     (byte_in),
    .cur_row     (cur_row),
    .cur_col     (cur_col),
    .cfg_we      (cfg_we),
    .cfg_sel     (paddr[2]),
    .cfg_data    (pwdata[7:0]),
    .cfg_rdata   (cfg_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .char_out    (char_out),
    .fore_color  (fore_color),
    .back_color  (back_color),
    .target_row  (target_row),
    .target_col  (target_col),
    .fill_count  (fill_count),
    .show_cursor (show_cursor),
    .last        (last)
  );

`ifndef SYNTHESIS
  // an accepted item blocks the input until it is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // results only go into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("output register overwritten");

  // finishing an item returns to idle
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !in_stall)
    else $error("not idle after item end");

  // colour walk and result load never overlap
  a_walk_no_load: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> !cmd.load_out && !cmd.commit)
    else $error("walk overlaps emission");
`endif

endmodule

// ----- hdl/aep_ctrl.sv -----
// Sequencing controller: accept, parameter walk, result emission.
module aep_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aep_pkg::aep_status_t st,
  output aep_pkg::aep_cmd_t    cmd
);
  import aep_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK} state_t;

  state_t           state;
  logic [1:0]       step;
  logic [IDX_W-1:0] widx;
  logic             walked;

  logic exec_go;
  logic last_step;
  logic walk_end;

  assign in_stall  = (state != S_IDLE);
  assign last_step = (step == st.n_res - 2'd1);
  assign walk_end  = ((CNT_W'(widx) + CNT_W'(1)) == st.sgr_cnt);
  assign exec_go   = (state == S_EXEC) && !(st.is_sgr && !walked);

  // commands
  always_comb begin
    cmd          = '0;
    cmd.step     = step;
    cmd.walk_idx = widx;
    cmd.latch_in = (state == S_IDLE) && in_valid;
    cmd.walk     = (state == S_WALK);
    if (exec_go) begin
      if (st.n_res == 2'd0) begin
        cmd.commit = 1'b1;
      end else if (st.out_free) begin
        cmd.load_out = 1'b1;
        cmd.commit   = last_step;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= 2'd0;
      widx   <= '0;
      walked <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state  <= S_EXEC;
            step   <= 2'd0;
            walked <= 1'b0;
          end
        end
        S_EXEC: begin
          if (st.is_sgr && !walked) begin
            state <= S_WALK;
            widx  <= '0;
          end else if (cmd.commit) begin
            state <= S_IDLE;
          end else if (cmd.load_out) begin
            step <= step + 2'd1;
          end
        end
        S_WALK: begin
          if (walk_end) begin
            walked <= 1'b1;
            state  <= S_EXEC;
          end else begin
            widx <= widx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/aep_datapath.sv -----
// Parser state, config registers, command decode and the output register.
module aep_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  aep_pkg::aep_cmd_t    cmd,
  output aep_pkg::aep_status_t st,
  input  logic [7:0]           byte_in,
  input  logic [7:0]           cur_row,
  input  logic [7:0]           cur_col,
  input  logic                 cfg_we,
  input  logic                 cfg_sel,
  input  logic [7:0]           cfg_data,
  output logic [7:0]           cfg_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [7:0]           char_out,
  output logic [3:0]           fore_color,
  output logic [3:0]           back_color,
  output logic [7:0]           target_row,
  output logic [7:0]           target_col,
  output logic [7:0]           fill_count,
  output logic                 show_cursor,
  output logic                 last
);
  import aep_pkg::*;

  typedef enum logic [1:0] {M_TEXT, M_ESC, M_CSI} mode_t;

  logic [7:0] screen_rows, screen_cols;
  mode_t      mode;
  logic [PARAM_BITS-1:0] pv [MAX_PARAMS];
  logic [CNT_W-1:0] pcount;
  logic       priv;
  logic [3:0] fg_now, bg_now, keep_fg, keep_bg;
  logic [7:0] keep_row, keep_col;
  logic       saved_valid;
  logic [7:0] b, row, col;

  // decode results
  logic [1:0] n_res;
  logic       is_sgr;
  logic [2:0] r_kind;
  logic [7:0] r_char, r_row, r_col, r_cnt;
  logic [3:0] r_fg, r_bg;
  logic       r_show;

  logic [7:0] rmax, cmax;
  logic [PARAM_BITS-1:0] p0, p1, nmv;
  logic signed [SUM_W-1:0] row_s, col_s, nmv_s, p0m1, p1m1;
  logic [7:0] fill_from, fill_to;
  logic is_digit, is_param_byte;
  logic [IDX_W-1:0] dig_idx;
  logic [PARAM_BITS+3:0] dig_val;
  logic [PARAM_BITS-1:0] wc;

  assign cfg_rdata = (cfg_sel == REG_COLS) ? screen_cols : screen_rows;
  assign st.n_res    = n_res;
  assign st.is_sgr   = is_sgr;
  assign st.out_free = !out_valid || !out_stall;
  assign st.sgr_cnt  = (pcount == '0) ? CNT_W'(1) : pcount;

  assign rmax  = ((screen_rows == 8'd0) ? ROWS_RESET : screen_rows) - 8'd1;
  assign cmax  = ((screen_cols == 8'd0) ? COLS_RESET : screen_cols) - 8'd1;
  assign p0    = pv[0];
  assign p1    = pv[1];
  assign nmv   = (p0 != '0) ? p0 : PARAM_BITS'(1);
  assign row_s = $signed({{(SUM_W-8){1'b0}}, row});
  assign col_s = $signed({{(SUM_W-8){1'b0}}, col});
  assign nmv_s = $signed({2'b00, nmv});
  assign p0m1  = (p0 != '0) ? $signed({2'b00, p0}) - SUM_W'(1) : '0;
  assign p1m1  = (p1 != '0) ? $signed({2'b00, p1}) - SUM_W'(1) : '0;

  assign is_digit      = (b >= "0") && (b <= "9");
  assign is_param_byte = is_digit || (b == ";") || ((b == "?") && (pcount == '0));
  assign dig_idx       = (pcount == '0) ? '0 : IDX_W'(pcount - CNT_W'(1));
  assign dig_val       = ({4'b0, pv[dig_idx]} << 3) + ({4'b0, pv[dig_idx]} << 1)
                         + (PARAM_BITS+4)'(b - "0");
  assign wc            = pv[cmd.walk_idx];

  // erase-line span
  always_comb begin
    fill_from = 8'd0;
    fill_to   = cmax;
    if (p0 == '0) fill_from = col;
    else if (p0 == PARAM_BITS'(1)) fill_to = (col > cmax) ? cmax : col;
  end

  // result decode for the current step
  always_comb begin
    n_res  = 2'd0;
    is_sgr = 1'b0;
    r_kind = KIND_CHAR;
    r_char = 8'd0;
    r_fg   = 4'd0;
    r_bg   = 4'd0;
    r_row  = 8'd0;
    r_col  = 8'd0;
    r_cnt  = 8'd0;
    r_show = 1'b0;
    unique case (mode)
      M_TEXT: begin
        if (b != CH_ESC) begin
          n_res  = 2'd1;
          r_char = b;
        end
      end
      M_ESC: begin
        if (b == "8") begin
          n_res = saved_valid ? 2'd2 : 2'd0;
          if (cmd.step == 2'd0) begin
            r_kind = KIND_COLOR; r_fg = keep_fg; r_bg = keep_bg;
          end else begin
            r_kind = KIND_CURSOR; r_row = keep_row; r_col = keep_col;
          end
        end else if (b == "c") begin
          n_res = 2'd3;
          if (cmd.step == 2'd0) r_kind = KIND_CLEAR;
          else if (cmd.step == 2'd1) r_kind = KIND_CURSOR;
          else begin
            r_kind = KIND_COLOR; r_fg = FG_DEFAULT; r_bg = BG_DEFAULT;
          end
        end else if (b != "[" && b != "7") begin
          n_res  = 2'd2;
          r_char = (cmd.step == 2'd0) ? CH_ESC : b;
        end
      end
      M_CSI: begin
        if (!is_param_byte) begin
          unique case (b)
            "m": begin
              is_sgr = 1'b1;
              n_res  = 2'd1;
              r_kind = KIND_COLOR; r_fg = fg_now; r_bg = bg_now;
            end
            "J": begin
              if (p0 == PARAM_BITS'(2) || p0 == PARAM_BITS'(3)) begin
                n_res  = 2'd2;
                r_kind = (cmd.step == 2'd0) ? KIND_CLEAR : KIND_CURSOR;
              end
            end
            "K": begin
              if (fill_to >= fill_from) begin
                n_res  = 2'd1;
                r_kind = KIND_FILL;
                r_row  = row;
                r_col  = fill_from;
                r_cnt  = fill_to - fill_from + 8'd1;
              end
            end
            "H", "f": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = clamp_pos(p0m1, rmax); r_col = clamp_pos(p1m1, cmax);
            end
            "A": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = clamp_pos(row_s - nmv_s, rmax); r_col = col;
            end
            "B": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = clamp_pos(row_s + nmv_s, rmax); r_col = col;
            end
            "C": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = row; r_col = clamp_pos(col_s + nmv_s, cmax);
            end
            "D": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = row; r_col = clamp_pos(col_s - nmv_s, cmax);
            end
            "E": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = clamp_pos(row_s + nmv_s, rmax);
            end
            "F": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = clamp_pos(row_s - nmv_s, rmax);
            end
            "G": begin
              n_res = 2'd1; r_kind = KIND_CURSOR;
              r_row = row; r_col = clamp_pos(p0m1, cmax);
            end
            "u": begin
              n_res = saved_valid ? 2'd2 : 2'd0;
              if (cmd.step == 2'd0) begin
                r_kind = KIND_COLOR; r_fg = keep_fg; r_bg = keep_bg;
              end else begin
                r_kind = KIND_CURSOR; r_row = keep_row; r_col = keep_col;
              end
            end
            "h", "l": begin
              if (priv && p0 == PARAM_BITS'(25)) begin
                n_res = 2'd1; r_kind = KIND_VIS; r_show = (b == "h");
              end
            end
            default: n_res = 2'd0;
          endcase
        end
      end
      default: n_res = 2'd0;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= ROWS_RESET;
      screen_cols <= COLS_RESET;
    end else if (cfg_we) begin
      if (cfg_sel == REG_COLS) screen_cols <= cfg_data;
      else screen_rows <= cfg_data;
    end
  end

  // latched input item
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      b   <= byte_in;
      row <= cur_row;
      col <= cur_col;
    end
  end

  // parser state: SGR walk and end-of-item updates
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_TEXT;
      pcount      <= '0;
      priv        <= 1'b0;
      fg_now      <= FG_DEFAULT;
      bg_now      <= BG_DEFAULT;
      keep_fg     <= FG_DEFAULT;
      keep_bg     <= BG_DEFAULT;
      keep_row    <= 8'd0;
      keep_col    <= 8'd0;
      saved_valid <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) pv[i] <= '0;
    end else if (cmd.walk) begin
      if (wc == '0) begin
        fg_now <= FG_DEFAULT;
        bg_now <= BG_DEFAULT;
      end else begin
        fg_now <= map_fg(wc, fg_now);
        bg_now <= map_bg(wc, bg_now);
      end
    end else if (cmd.commit) begin
      unique case (mode)
        M_TEXT: begin
          if (b == CH_ESC) mode <= M_ESC;
        end
        M_ESC: begin
          mode <= M_TEXT;
          if (b == "[") begin
            mode   <= M_CSI;
            pcount <= '0;
            priv   <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++) pv[i] <= '0;
          end else if (b == "7") begin
            keep_row <= row; keep_col <= col;
            keep_fg  <= fg_now; keep_bg <= bg_now;
            saved_valid <= 1'b1;
          end else if (b == "8") begin
            if (saved_valid) begin
              fg_now <= keep_fg; bg_now <= keep_bg;
            end
          end else if (b == "c") begin
            fg_now <= FG_DEFAULT; bg_now <= BG_DEFAULT;
          end
        end
        M_CSI: begin
          if (is_digit) begin
            if (pcount == '0) pcount <= CNT_W'(1);
            pv[dig_idx] <= (dig_val > {4'b0, PARAM_MAX}) ? PARAM_MAX
                                                         : dig_val[PARAM_BITS-1:0];
          end else if (b == ";") begin
            if (pcount == '0) pcount <= CNT_W'(2);
            else if (pcount < CNT_W'(MAX_PARAMS)) pcount <= pcount + CNT_W'(1);
          end else if (b == "?" && pcount == '0) begin
            priv <= 1'b1;
          end else begin
            mode <= M_TEXT;
            if (b == "s") begin
              keep_row <= row; keep_col <= col;
              keep_fg  <= fg_now; keep_bg <= bg_now;
              saved_valid <= 1'b1;
            end else if (b == "u" && saved_valid) begin
              fg_now <= keep_fg; bg_now <= keep_bg;
            end
          end
        end
        default: mode <= M_TEXT;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind        <= r_kind;
      char_out    <= r_char;
      fore_color  <= r_fg;
      back_color  <= r_bg;
      target_row  <= r_row;
      target_col  <= r_col;
      fill_count  <= r_cnt;
      show_cursor <= r_show;
      last        <= (cmd.step == n_res - 2'd1);
    end
  end

endmodule
